>>> hw/rtl/haversine_distance_top_assert.svh
// Assertion macros shared by the haversine distance RTL.
`ifndef HAVERSINE_DISTANCE_TOP_ASSERT_SVH
`define HAVERSINE_DISTANCE_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define HD_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HD_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hw/rtl/hd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hd_pkg;
    localparam int FRAC_BITS = 32;
    localparam int NCORD = FRAC_BITS;
    localparam int NSQ = 64;
    localparam int SHIFT_W = $clog2(NCORD);
    localparam logic signed [63:0] TURN_HU = 64'sd720000000;
    localparam logic signed [63:0] HALF_HU = 64'sd360000000;
    localparam logic signed [63:0] QUARTER_HU = 64'sd180000000;
    localparam logic [63:0] RAD_PER_HU_Q62 = 64'd40244552545;
    localparam logic [63:0] ATAN1_Q62 = 64'd3622009729038561419;
    localparam logic [63:0] GAININV_Q62 = 64'd2800459870029452954;
    localparam logic [63:0] DIAM_DM = 64'd127420000;
    localparam logic [27:0] DIST_MAX = 28'hFFFFFFF;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    typedef logic [63:0] word_t;
    typedef logic [SHIFT_W-1:0] shift_t;

    function automatic word_t q62_to_f(input word_t v);
        q62_to_f = (v + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    endfunction

    // Arctangent of 2^-i in Q(FRAC_BITS), from the alternating series in Q62 (a Q62 constant for i = 0).
    function automatic word_t atan_entry(input int i);
        word_t acc;
        word_t term;
        int e;
        acc = '0;
        if (i == 0) begin
            acc = ATAN1_Q62;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = 62 - (2 * k + 1) * i;
                if (e >= 0) begin
                    term = (64'd1 << e) / 64'(2 * k + 1);
                    if ((k % 2) == 1) acc = acc - term;
                    else acc = acc + term;
                end
            end
        end
        atan_entry = q62_to_f(acc);
    endfunction

    typedef struct packed {
        logic valid;
        word_t x;
        word_t y;
        word_t z;
    } cord_t;
endpackage
`default_nettype wire

>>> hw/rtl/hd_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface hd_stream_if #(parameter int WIDTH = 8);
    logic valid;
    logic ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hd_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One CORDIC micro-rotation; the shift, the angle step and the mode are tied
// to constants where the cell is placed in its chain.
module hd_cordic_cell (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire hd_pkg::shift_t shift,
    input  wire logic vec_mode,
    input  wire hd_pkg::word_t atan,
    input  wire hd_pkg::cord_t in_c,
    output hd_pkg::cord_t out_c
);
    hd_pkg::word_t xi;
    hd_pkg::word_t yi;
    logic up;
    hd_pkg::cord_t out_next;
    logic valid_reg;
    hd_pkg::word_t x_reg;
    hd_pkg::word_t y_reg;
    hd_pkg::word_t z_reg;
    assign xi = hd_pkg::word_t'($signed(in_c.x) >>> shift);
    assign yi = hd_pkg::word_t'($signed(in_c.y) >>> shift);
    assign up = vec_mode ? !in_c.y[63] : !in_c.z[63];
    always_comb
    begin
        out_next.valid = in_c.valid;
        if (up)
        begin
            out_next.x = vec_mode ? in_c.x + yi : in_c.x - yi;
            out_next.y = vec_mode ? in_c.y - xi : in_c.y + xi;
            out_next.z = vec_mode ? in_c.z + atan : in_c.z - atan;
        end
        else
        begin
            out_next.x = vec_mode ? in_c.x - yi : in_c.x + yi;
            out_next.y = vec_mode ? in_c.y + xi : in_c.y - xi;
            out_next.z = vec_mode ? in_c.z - atan : in_c.z + atan;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= out_next.valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= out_next.x;
            y_reg <= out_next.y;
            z_reg <= out_next.z;
        end
    end
    assign out_c = '{valid_reg, x_reg, y_reg, z_reg};
endmodule
`default_nettype wire

>>> hw/rtl/hd_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One digit of a restoring square root; radicand bits shift out at the top.
module hd_sqrt_cell (
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [127:0] rad_in,
    input  wire logic [65:0] rem_in,
    input  wire logic [63:0] root_in,
    output logic [127:0] rad_out,
    output logic [65:0] rem_out,
    output logic [63:0] root_out
);
    logic [65:0] rem_sh;
    logic [65:0] trial;
    assign rem_sh = {rem_in[63:0], rad_in[127:126]};
    assign trial = {root_in, 2'b01};
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_out <= {rad_in[125:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_out <= rem_sh - trial;
                root_out <= {root_in[62:0], 1'b1};
            end
            else
            begin
                rem_out <= rem_sh;
                root_out <= {root_in[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/hd_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// Angle reduction, radian scaling and a chain of rotation cells.
module hd_sincos (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic in_valid,
    input  wire logic signed [31:0] ang,
    output logic out_valid,
    output hd_pkg::word_t sin_q,
    output hd_pkg::word_t cos_q
);
    localparam int N = hd_pkg::NCORD;
    logic signed [63:0] w0;
    logic signed [63:0] w1;
    logic signed [63:0] w2;
    logic flip_c;
    logic [31:0] mag;
    logic s1_valid_reg;
    logic s1_neg_reg;
    logic s1_flip_reg;
    logic [31:0] s1_mag_reg;
    hd_pkg::word_t prod;
    hd_pkg::word_t zr;
    hd_pkg::cord_t chain [0:N];
    logic flip_pipe [0:N];
    always_comb
    begin
        w0 = 64'(ang);
        w1 = w0;
        if (w0 >= hd_pkg::HALF_HU) w1 = w0 - hd_pkg::TURN_HU;
        else if (w0 < -hd_pkg::HALF_HU) w1 = w0 + hd_pkg::TURN_HU;
        w2 = w1;
        flip_c = 1'b0;
        if (w1 > hd_pkg::QUARTER_HU)
        begin
            w2 = hd_pkg::HALF_HU - w1;
            flip_c = 1'b1;
        end
        else if (w1 < -hd_pkg::QUARTER_HU)
        begin
            w2 = -hd_pkg::HALF_HU - w1;
            flip_c = 1'b1;
        end
        mag = w2[63] ? 32'(-w2) : 32'(w2);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (en) s1_valid_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg <= w2[63];
            s1_flip_reg <= flip_c;
            s1_mag_reg <= mag;
        end
    end
    assign prod = ((64'(s1_mag_reg) * hd_pkg::RAD_PER_HU_Q62)
                   + (64'd1 << (61 - hd_pkg::FRAC_BITS))) >> (62 - hd_pkg::FRAC_BITS);
    assign zr = s1_neg_reg ? (64'd0 - prod) : prod;
    always_comb
    begin
        chain[0].valid = s1_valid_reg;
        chain[0].x = hd_pkg::q62_to_f(hd_pkg::GAININV_Q62);
        chain[0].y = '0;
        chain[0].z = zr;
    end
    assign flip_pipe[0] = s1_flip_reg;
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam hd_pkg::word_t ATAN_I = hd_pkg::atan_entry(i);
        hd_cordic_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .shift(hd_pkg::shift_t'(i)),
            .vec_mode(1'b0), .atan(ATAN_I), .in_c(chain[i]), .out_c(chain[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en) flip_pipe[i+1] <= flip_pipe[i];
        end
    end
    assign out_valid = chain[N].valid;
    assign sin_q = chain[N].y;
    assign cos_q = flip_pipe[N] ? (64'd0 - chain[N].x) : chain[N].x;
endmodule
`default_nettype wire

>>> hw/rtl/hd_mulq.sv
`timescale 1ns / 1ps
`default_nettype none
// Signed Q(F) product truncated toward zero, in four 32x32 partial products
// over two register stages.
module hd_mulq (
    input  wire logic clk,
    input  wire logic en,
    input  wire hd_pkg::word_t a,
    input  wire hd_pkg::word_t b,
    output hd_pkg::word_t p
);
    hd_pkg::word_t ma;
    hd_pkg::word_t mb;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic neg_reg;
    logic [127:0] full;
    hd_pkg::word_t r;
    assign ma = a[63] ? 64'd0 - a : a;
    assign mb = b[63] ? 64'd0 - b : b;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg <= 64'(ma[31:0]) * 64'(mb[31:0]);
            p01_reg <= 64'(ma[31:0]) * 64'(mb[63:32]);
            p10_reg <= 64'(ma[63:32]) * 64'(mb[31:0]);
            p11_reg <= 64'(ma[63:32]) * 64'(mb[63:32]);
            neg_reg <= a[63] ^ b[63];
        end
    end
    assign full = 128'(p00_reg) + (128'(p01_reg) << 32) + (128'(p10_reg) << 32)
                  + (128'(p11_reg) << 64);
    assign r = full[hd_pkg::FRAC_BITS +: 64];
    always_ff @(posedge clk)
    begin
        if (en) p <= neg_reg ? 64'd0 - r : r;
    end
endmodule
`default_nettype wire

>>> hw/rtl/haversine_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Haversine great-circle distance: one transaction in, one transaction out.
// Throughput: one point pair per cycle; the pipeline advances whenever the
// output register is empty or being taken. The result passes through 136
// register stages: reduction and rotation 33, products 4, clamp 1, root chain 64,
// vectoring chain 32, final scaling 2.
// Reset (rst_n low, asynchronous) clears all valid flags; no data is kept.
module haversine_distance_top (
    input  wire logic clk,
    input  wire logic rst_n,
    hd_stream_if.sink in_if,
    hd_stream_if.source out_if
);
    localparam int N = hd_pkg::NCORD;
    localparam int MUL_LAT = 2;

    // One global enable: the whole chain moves unless the output is stalled.
    logic en;
    assign en = !out_if.valid || out_if.ready;
    assign in_if.ready = en;

    logic signed [27:0] lat_a, lat_b;
    logic signed [28:0] lon_a, lon_b;
    assign lat_a = in_if.data[27:0];
    assign lon_a = in_if.data[56:28];
    assign lat_b = in_if.data[84:57];
    assign lon_b = in_if.data[113:85];

    logic in_valid;
    assign in_valid = in_if.valid && in_if.ready;

    // Four angles in half-microdegrees.
    logic signed [31:0] ang_u, ang_v, ang_a, ang_b;
    assign ang_u = 32'(lat_b) - 32'(lat_a);
    assign ang_v = 32'(lon_b) - 32'(lon_a);
    assign ang_a = 32'(lat_a) <<< 1;
    assign ang_b = 32'(lat_b) <<< 1;

    logic v_sc;
    logic v_u, v_v, v_b;
    hd_pkg::word_t su, cu, sv, cv, sa, ca, sb, cb;
    hd_sincos u_sc_u (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .ang(ang_u), .out_valid(v_sc), .sin_q(su), .cos_q(cu));
    hd_sincos u_sc_v (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .ang(ang_v), .out_valid(v_u), .sin_q(sv), .cos_q(cv));
    hd_sincos u_sc_a (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .ang(ang_a), .out_valid(v_v), .sin_q(sa), .cos_q(ca));
    hd_sincos u_sc_b (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
        .ang(ang_b), .out_valid(v_b), .sin_q(sb), .cos_q(cb));

    // First product level: su^2, ca*cb, sv^2.
    hd_pkg::word_t p_uu, p_ab, p_vv, p_abvv, p_uu_d1_reg, p_uu_d2_reg;
    hd_mulq u_m_uu (.clk(clk), .en(en), .a(su), .b(su), .p(p_uu));
    hd_mulq u_m_ab (.clk(clk), .en(en), .a(ca), .b(cb), .p(p_ab));
    hd_mulq u_m_vv (.clk(clk), .en(en), .a(sv), .b(sv), .p(p_vv));
    hd_mulq u_m_x (.clk(clk), .en(en), .a(p_ab), .b(p_vv), .p(p_abvv));

    logic [2*MUL_LAT-1:0] vmul_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vmul_reg <= '0;
        else if (en) vmul_reg <= {vmul_reg[2*MUL_LAT-2:0], v_sc};
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_uu_d1_reg <= p_uu;
            p_uu_d2_reg <= p_uu_d1_reg;
        end
    end

    // Sum and clamp of h, then the two radicands.
    hd_pkg::word_t h_sum, h_cl;
    logic hv_reg;
    hd_pkg::word_t h_reg;
    assign h_sum = p_uu_d2_reg + p_abvv;
    always_comb
    begin
        h_cl = h_sum;
        if (h_sum[63]) h_cl = '0;
        else if (h_sum > hd_pkg::ONE) h_cl = hd_pkg::ONE;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) hv_reg <= 1'b0;
        else if (en) hv_reg <= vmul_reg[2*MUL_LAT-1];
    end
    always_ff @(posedge clk)
    begin
        if (en) h_reg <= h_cl;
    end

    // Two root chains, one digit per cell.
    logic [127:0] rad_h [0:hd_pkg::NSQ];
    logic [127:0] rad_c [0:hd_pkg::NSQ];
    logic [65:0] rem_h [0:hd_pkg::NSQ];
    logic [65:0] rem_c [0:hd_pkg::NSQ];
    logic [63:0] rt_h [0:hd_pkg::NSQ];
    logic [63:0] rt_c [0:hd_pkg::NSQ];
    logic [hd_pkg::NSQ:0] sqv_reg;
    hd_pkg::word_t one_m_h;
    assign one_m_h = hd_pkg::ONE - h_reg;
    assign rad_h[0] = 128'(h_reg) << hd_pkg::FRAC_BITS;
    assign rad_c[0] = 128'(one_m_h) << hd_pkg::FRAC_BITS;
    assign rem_h[0] = '0;
    assign rem_c[0] = '0;
    assign rt_h[0] = '0;
    assign rt_c[0] = '0;
    assign sqv_reg[0] = hv_reg;
    for (genvar j = 0; j < hd_pkg::NSQ; j++)
    begin : g_sq
        hd_sqrt_cell u_sh (.clk(clk), .en(en), .rad_in(rad_h[j]), .rem_in(rem_h[j]),
            .root_in(rt_h[j]), .rad_out(rad_h[j+1]), .rem_out(rem_h[j+1]),
            .root_out(rt_h[j+1]));
        hd_sqrt_cell u_sc (.clk(clk), .en(en), .rad_in(rad_c[j]), .rem_in(rem_c[j]),
            .root_in(rt_c[j]), .rad_out(rad_c[j+1]), .rem_out(rem_c[j+1]),
            .root_out(rt_c[j+1]));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) sqv_reg[j+1] <= 1'b0;
            else if (en) sqv_reg[j+1] <= sqv_reg[j];
        end
    end

    // Vectoring chain for the arc.
    hd_pkg::cord_t vc [0:N];
    always_comb
    begin
        vc[0].valid = sqv_reg[hd_pkg::NSQ];
        vc[0].x = rt_c[hd_pkg::NSQ];
        vc[0].y = rt_h[hd_pkg::NSQ];
        vc[0].z = '0;
    end
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        localparam hd_pkg::word_t ATAN_I = hd_pkg::atan_entry(i);
        hd_cordic_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en), .shift(hd_pkg::shift_t'(i)),
            .vec_mode(1'b1), .atan(ATAN_I), .in_c(vc[i]), .out_c(vc[i+1]));
    end

    // Distance scaling: z times the diameter in two stages.
    hd_pkg::word_t zc;
    assign zc = vc[N].z[63] ? '0 : vc[N].z;
    logic [63:0] dlo_reg, dhi_reg;
    logic dv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dv_reg <= 1'b0;
        else if (en) dv_reg <= vc[N].valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlo_reg <= 64'(zc[31:0]) * 64'(hd_pkg::DIAM_DM[31:0]);
            dhi_reg <= 64'(zc[63:32]) * 64'(hd_pkg::DIAM_DM[31:0]);
        end
    end
    logic [127:0] dfull;
    hd_pkg::word_t dq;
    logic [27:0] dsat;
    assign dfull = 128'(dlo_reg) + (128'(dhi_reg) << 32);
    assign dq = dfull[hd_pkg::FRAC_BITS +: 64];
    assign dsat = (dq > 64'(hd_pkg::DIST_MAX)) ? hd_pkg::DIST_MAX : dq[27:0];

    logic out_valid_reg;
    logic [27:0] out_data_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) out_valid_reg <= 1'b0;
        else if (en) out_valid_reg <= dv_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en) out_data_reg <= dsat;
    end
    assign out_if.valid = out_valid_reg;
    assign out_if.data = out_data_reg;

    `include "haversine_distance_top_assert.svh"
    `HD_ASSERT_IMP(a_sc_lockstep, clk, rst_n, 1'b1, (v_sc == v_u) && (v_u == v_v) && (v_v == v_b))
    `HD_ASSERT_IMP(a_h_clamped, clk, rst_n, hv_reg, h_reg <= hd_pkg::ONE)
    `HD_ASSERT_NXT(a_stall_hold, clk, rst_n, out_if.valid && !out_if.ready, out_if.valid)
endmodule
`default_nettype wire
